// ===== src/cmap4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_pkg: shared types and constants of the cmap format-4 lookup core
// Command codes, sequencer states and the result and status structs that
// pass between the search sequencer and the top level.
// ----------------------------------------------------------------------------
package cmap4_pkg;

	// Width of a full table address before it is range checked. The largest
	// glyph address is 3*255+1+254 + 32767 + 65535, which fits in 17 bits.
	localparam int FADDR_W = 17;
	localparam int SEG_W   = 8;
	localparam int WORD_W  = 16;
	localparam int WADDR_W = 10;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmap4_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_END_RD,
		ST_END_CHK,
		ST_START_CHK,
		ST_F_END,
		ST_F_START,
		ST_F_DELTA,
		ST_F_ROFF,
		ST_F_GLYPH,
		ST_F_GCHK,
		ST_DONE
	} cmap4_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] glyph;
		logic              mapped;
		logic              fault;
	} cmap4_result_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} cmap4_seq_stat_t;

endpackage

// ===== src/cmap4_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_ram: table word store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module cmap4_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/cmap4_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_seq: segment search sequencer
// Binary-searches the end and start code arrays through the table store,
// then fetches delta, range offset and, if needed, the glyph word.
// ----------------------------------------------------------------------------
module cmap4_seq #(
	parameter int TABLE_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cmap4_pkg::WORD_W-1:0]  code,
	input  logic [cmap4_pkg::SEG_W-1:0]   num_segs,
	input  logic                          res_take,
	output logic                          rd_en,
	output logic [$clog2(TABLE_WORDS)-1:0] rd_addr,
	input  logic [cmap4_pkg::WORD_W-1:0]  rd_data,
	output cmap4_pkg::cmap4_seq_stat_t    stat,
	output cmap4_pkg::cmap4_result_t      result
);
	import cmap4_pkg::*;

	localparam int AW = $clog2(TABLE_WORDS);
	localparam logic [FADDR_W-1:0] TW = FADDR_W'(TABLE_WORDS);

	cmap4_state_t      state_q, state_d;
	logic [SEG_W-1:0]  seg_q;
	logic [WORD_W-1:0] code_q;
	logic [SEG_W:0]    lo_q, hi_q;
	logic [SEG_W-1:0]  probe_q;
	logic [WORD_W-1:0] end_q, start_q, delta_q;
	logic              rd_ok_s1;
	cmap4_result_t     res_q;

	logic [SEG_W:0]     sum_w;
	logic [SEG_W-1:0]   probe_w;
	logic [SEG_W:0]     lo_inc_w;
	logic [WORD_W-1:0]  data_w;
	logic [FADDR_W-1:0] start_addr_w, delta_addr_w, roff_addr_w, glyph_addr_w;
	logic [FADDR_W-1:0] raddr_w;
	logic               contained_w;

	assign sum_w    = lo_q + hi_q;
	assign probe_w  = sum_w[SEG_W:1];
	assign lo_inc_w = {1'b0, probe_q} + (SEG_W+1)'(1);

	// Words fetched beyond the store read as zero.
	assign data_w = rd_ok_s1 ? rd_data : '0;

	assign start_addr_w = FADDR_W'(seg_q) + FADDR_W'(probe_q) + FADDR_W'(1);
	assign delta_addr_w = start_addr_w + FADDR_W'(seg_q);
	assign roff_addr_w  = delta_addr_w + FADDR_W'(seg_q);
	assign glyph_addr_w = roff_addr_w + FADDR_W'(data_w[WORD_W-1:1])
		+ FADDR_W'(code_q - start_q);

	assign contained_w = !(code_q < data_w) && !(end_q < code_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (num_segs == '0) ? ST_DONE : ST_END_RD;
				end
			end
			ST_END_RD: state_d = ST_END_CHK;
			ST_END_CHK: begin
				if (data_w < code_q) begin
					state_d = (lo_inc_w < hi_q) ? ST_END_RD : ST_F_END;
				end else begin
					state_d = ST_START_CHK;
				end
			end
			ST_START_CHK: begin
				if (data_w <= code_q) begin
					state_d = ST_F_END;
				end else begin
					state_d = (lo_q < {1'b0, probe_q}) ? ST_END_RD : ST_F_END;
				end
			end
			ST_F_END:   state_d = ST_F_START;
			ST_F_START: state_d = ST_F_DELTA;
			ST_F_DELTA: state_d = contained_w ? ST_F_ROFF : ST_DONE;
			ST_F_ROFF:  state_d = ST_F_GLYPH;
			ST_F_GLYPH: begin
				if (data_w == '0 || glyph_addr_w >= TW) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_F_GCHK;
				end
			end
			ST_F_GCHK: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Read requests and status.
	always_comb begin
		rd_en   = 1'b0;
		raddr_w = '0;
		unique case (state_q)
			ST_END_RD: begin
				rd_en   = 1'b1;
				raddr_w = FADDR_W'(probe_w);
			end
			ST_END_CHK: begin
				rd_en   = 1'b1;
				raddr_w = start_addr_w;
			end
			ST_F_END: begin
				rd_en   = 1'b1;
				raddr_w = FADDR_W'(probe_q);
			end
			ST_F_START: begin
				rd_en   = 1'b1;
				raddr_w = start_addr_w;
			end
			ST_F_DELTA: begin
				rd_en   = 1'b1;
				raddr_w = delta_addr_w;
			end
			ST_F_ROFF: begin
				rd_en   = 1'b1;
				raddr_w = roff_addr_w;
			end
			ST_F_GLYPH: begin
				rd_en   = 1'b1;
				raddr_w = glyph_addr_w;
			end
			default: begin
				rd_en   = 1'b0;
				raddr_w = '0;
			end
		endcase
		stat.ready     = (state_q == ST_IDLE);
		stat.res_valid = (state_q == ST_DONE);
	end

	assign rd_addr = raddr_w[AW-1:0];
	assign result  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_ok_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_ok_s1 <= rd_en && (raddr_w < TW);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				seg_q  <= num_segs;
				code_q <= code;
				lo_q   <= '0;
				hi_q   <= {1'b0, num_segs};
				res_q  <= '0;
			end
			ST_END_RD: probe_q <= probe_w;
			ST_END_CHK: begin
				if (data_w < code_q) begin
					lo_q <= lo_inc_w;
				end
			end
			ST_START_CHK: begin
				if (data_w > code_q) begin
					hi_q <= {1'b0, probe_q};
				end
			end
			ST_F_START: end_q <= data_w;
			ST_F_DELTA: begin
				start_q <= data_w;
				res_q   <= '{glyph: '0, mapped: contained_w, fault: 1'b0};
			end
			ST_F_ROFF: delta_q <= data_w;
			ST_F_GLYPH: begin
				if (data_w == '0) begin
					res_q.glyph <= delta_q + code_q;
				end else if (glyph_addr_w >= TW) begin
					res_q.fault <= 1'b1;
				end
			end
			ST_F_GCHK: begin
				res_q.glyph <= (rd_data == '0) ? '0 : rd_data + delta_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

// ===== src/cmap4_glyph_lookup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_glyph_lookup_core: cmap format-4 character to glyph lookup
// Holds the table in a word store and searches it per lookup word.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries write and lookup words, told apart by s_tuser.
// A write word stores one table word in the cycle it is accepted and gives
// no result. A lookup word yields one result word on the master stream.
// The user must set segment_count through cfg_wr_en/cfg_wr_data only while
// the core is idle; the core does not enforce this. A lookup runs search
// probes, each reading the end code and checking the start code when the end
// code is not below the character code, up to 8 probes for 255 segments, then
// the final fetches of end code, start code, delta, range offset and, if
// needed, the glyph word, then the done state; a segment_count of 0 goes
// straight to the done state. The next word can be taken as soon as the
// result enters the output register. Lookups run one at a time since every
// step waits on the single store read port. A new word is accepted while the
// previous result still waits in the output register; a stalled receiver
// holds the search at its end until the output register frees.
// Reset clears the sequencer and the output valid and sets segment_count to
// 1; the store contents are undefined until written.
// ----------------------------------------------------------------------------
module cmap4_glyph_lookup_core #(
	parameter int TABLE_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: segment_count.
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: word_addr[9:0], word_data[25:10], char_code[41:26], zero pad.
	input  logic [47:0] s_tdata,
	// tuser: cmd.
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: glyph_index[15:0].
	output logic [15:0] m_tdata,
	// tuser: mapped[0], addr_fault[1].
	output logic [1:0]  m_tuser
);
	import cmap4_pkg::*;

	localparam int AW = $clog2(TABLE_WORDS);
	localparam logic [FADDR_W-1:0] TW = FADDR_W'(TABLE_WORDS);

	logic [SEG_W-1:0]   num_segs_q;
	logic               in_acc;
	logic [WADDR_W-1:0] word_addr;
	logic [WORD_W-1:0]  word_data, char_code;
	logic [FADDR_W-1:0] waddr_full;
	logic               wr_en;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [WORD_W-1:0]  rd_data;
	logic               res_take;
	cmap4_seq_stat_t    stat;
	cmap4_result_t      result;
	logic               out_valid_q;
	cmap4_result_t      out_q;

	assign word_addr  = s_tdata[9:0];
	assign word_data  = s_tdata[25:10];
	assign char_code  = s_tdata[41:26];
	assign waddr_full = FADDR_W'(word_addr);

	assign s_tready = stat.ready;
	assign in_acc   = s_tvalid && s_tready;
	assign wr_en    = in_acc && (cmap4_cmd_t'(s_tuser) == CMD_WRITE) && (waddr_full < TW);
	assign res_take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_segs_q <= SEG_W'(1);
		end else if (cfg_wr_en) begin
			num_segs_q <= cfg_wr_data;
		end
	end

	cmap4_ram #(
		.DEPTH(TABLE_WORDS),
		.WIDTH(WORD_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(waddr_full[AW-1:0]),
		.wr_data(word_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	cmap4_seq #(
		.TABLE_WORDS(TABLE_WORDS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc && (cmap4_cmd_t'(s_tuser) == CMD_LOOKUP)),
		.code     (char_code),
		.num_segs (num_segs_q),
		.res_take (res_take),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.stat     (stat),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid && res_take) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.glyph;
	assign m_tuser  = {out_q.fault, out_q.mapped};

`ifndef ASSERT_OFF
	// A finished lookup waits for the output register and keeps its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && !res_take |=> stat.res_valid && $stable(result))
		else $error("lookup result dropped while output register was full");

	// A lookup occupies the sequencer: no word is taken in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (cmap4_cmd_t'(s_tuser) == CMD_LOOKUP) |=> !s_tready)
		else $error("word accepted while a lookup was in progress");

	// An unmapped or faulting result carries glyph zero; a fault implies mapped.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (!m_tuser[0] || m_tuser[1]) |-> m_tdata == '0 && (m_tuser[0] || !m_tuser[1]))
		else $error("inconsistent result flags");
`endif

endmodule
